[design/utf8d_pkg.sv]
package utf8d_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [1:0]  CONT_TAG       = 2'b10;

  typedef struct packed {
    logic load;   // take the offered byte into the hold buffer
    logic step;   // run one decode pass over the hold buffer
  } dp_cmd_t;

  typedef struct packed {
    logic has_result;  // the current pass yields a code point
    logic more;        // another result follows the current one for this byte
    logic out_free;    // output register can take a new result this cycle
  } dp_status_t;

  // Sequence length called for by a lead byte; zero for an invalid lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b < 8'h80)                     len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0)     len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0)     len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0)     len = 3'd4;
    return len;
  endfunction

endpackage

[design/utf8d_datapath.sv]
module utf8d_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  utf8d_pkg::dp_cmd_t    cmd,
  output utf8d_pkg::dp_status_t status,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_buffer,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [23:0]           m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);
  import utf8d_pkg::*;

  logic [7:0]  held [4];
  logic [2:0]  count;
  logic        eob;

  logic [7:0]  shifted [4];
  logic [2:0]  count_next;
  logic [2:0]  len;
  logic [2:0]  drop;
  logic [2:0]  next_len;
  logic        bad_cont;
  logic        has_result;
  logic        err;
  logic [20:0] cp;
  logic [2:0]  src;

  logic [20:0] out_cp;
  logic        out_err;
  logic        out_last;
  logic        out_valid;

  always_comb begin
    len = seq_len(held[0]);
    bad_cont = (len >= 3'd2 && held[1][7:6] != CONT_TAG) ||
               (len >= 3'd3 && held[2][7:6] != CONT_TAG) ||
               (len == 3'd4 && held[3][7:6] != CONT_TAG);
    has_result = 1'b1;
    err        = 1'b1;
    cp         = REPLACEMENT_CP;
    drop       = 3'd1;
    if (len == 3'd0) begin
      drop = 3'd1;
    end else if (count < len) begin
      // incomplete sequence: only reported when the buffer ends here
      has_result = eob;
      drop       = 3'd4;
    end else if (bad_cont) begin
      drop = 3'd1;
    end else begin
      err  = 1'b0;
      drop = len;
      case (len)
        3'd1:    cp = {13'd0, held[0]};
        3'd2:    cp = {10'd0, held[0][4:0], held[1][5:0]};
        3'd3:    cp = {5'd0, held[0][3:0], held[1][5:0], held[2][5:0]};
        default: cp = {held[0][2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
      endcase
    end

    count_next = (drop >= count) ? 3'd0 : count - drop;
    for (int i = 0; i < 4; i++) begin
      src = 3'(i) + drop;
      shifted[i] = (src < 3'd4) ? held[src[1:0]] : held[i];
    end

    // look one pass ahead to tag the last result of this byte
    next_len = seq_len(shifted[0]);
    status.has_result = has_result;
    status.more       = has_result && (count_next != 3'd0) &&
                        ((next_len == 3'd0) || (count_next >= next_len) || eob);
    status.out_free   = !out_valid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held[count[1:0]] <= data_byte;
      eob              <= end_of_buffer;
    end else if (cmd.step) begin
      for (int i = 0; i < 4; i++) held[i] <= shifted[i];
    end
    if (cmd.step && has_result) begin
      out_cp   <= cp;
      out_err  <= err;
      out_last <= !status.more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load)      count <= count + 3'd1;
      else if (cmd.step) count <= count_next;
      if (cmd.step && has_result) out_valid <= 1'b1;
      else if (m_tready)          out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_cp};
  assign m_tuser  = out_err;
  assign m_tlast  = out_last;

endmodule

[design/utf8d_ctrl.sv]
module utf8d_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  utf8d_pkg::dp_status_t status,
  output utf8d_pkg::dp_cmd_t    cmd
);
  import utf8d_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status.has_result) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
          if (!status.more) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

[design/utf8_byte_stream_decoder_core.sv]
// UTF-8 byte stream decoder.
// Slave channel: one raw byte per request on s_tdata, s_tlast marks the last
// byte of a buffer. Master channel: one code point per request, with the
// error flag on m_tuser and m_tlast set on the last code point a byte causes.
// A byte is taken into the four-byte hold buffer; each decode pass over the
// buffer then gives at most one code point. A byte releases from one to four
// code points, one per pass, or none when it only extends a pending sequence.
// Passes run one per cycle through the controller while the output register
// is free, so a bad continuation rescan adds a pass per extra code point.
// A code point shows on the master side in the cycle after its pass.
// The output register lets the next byte be taken while a result waits.
// When the receiver stalls, the pending pass waits and the held result stays
// put; no byte is taken until every result of the current byte has reached
// the output register.
// Synchronous reset empties the hold buffer and the output register.
module utf8_byte_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // [0] decode_error
  output logic        m_tlast    // run_last
);
  import utf8d_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  utf8d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  utf8d_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .data_byte     (s_tdata),
    .end_of_buffer (s_tlast),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule
